// ===== sv/kalman_point_tracker_core_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the point tracker core
// Implication checks sampled on the core clock, off while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef KALMAN_POINT_TRACKER_CORE_DEFINES_SVH
`define KALMAN_POINT_TRACKER_CORE_DEFINES_SVH

// same-cycle implication
`define KPT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define KPT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/kpt_pkg.sv =====
// ---------------------------------------------------------------------------
// kpt_pkg
// Shared types, constants and helpers of the point tracker core.
// ---------------------------------------------------------------------------
`default_nettype none
package kpt_pkg;

	localparam int KPT_HISTORY_DEPTH = 32;

	// register reset values, unsigned Q16.16
	localparam logic [31:0] KPT_Q_RST = 32'd655;
	localparam logic [31:0] KPT_R_RST = 32'd6554;
	localparam logic [31:0] KPT_P_RST = 32'd65536;

	// register indexes
	typedef enum logic [1:0] {
		CFG_PROCESS_NOISE = 2'd0,
		CFG_MEAS_NOISE    = 2'd1,
		CFG_INIT_COV      = 2'd2
	} kpt_cfg_idx_t;

	// heading codes
	typedef enum logic [3:0] {
		HD_STILL = 4'd0, HD_R  = 4'd1, HD_DR = 4'd2, HD_D  = 4'd3, HD_DL = 4'd4,
		HD_L     = 4'd5, HD_UL = 4'd6, HD_U  = 4'd7, HD_UR = 4'd8
	} kpt_heading_t;
	localparam logic [3:0] KPT_HEAD_MAX = 4'd8;

	// divider: 63 quotient bits, quotient capped at 2^62
	localparam int          KPT_DIV_STEPS = 63;
	localparam logic [62:0] KPT_QUOT_CAP  = 63'h4000_0000_0000_0000;
	localparam int          KPT_MUL_STEPS = 4;

	// datapath commands
	typedef struct packed {
		logic       take;
		logic       seed;
		logic       pred;
		logic       pred2;
		logic       md_ld;
		logic       hm_ld;
		logic       mul_step;
		logic [1:0] mul_j;
		logic       div_init;
		logic       div_step;
		logic       md_st;
		logic       hm_st;
		logic       upd;
		logic       push;
		logic       rd;
		logic       hcalc;
		logic       ld_out;
		logic       ax;
		logic [2:0] k;
	} kpt_cmd_t;

	typedef struct packed {
		logic pos;
		logic started;
	} kpt_stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
		if (v[64:31] == {34{v[64]}})
			return v[31:0];
		return v[64] ? 32'h8000_0000 : 32'h7fff_ffff;
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [64:0] v);
		if (v[64:47] == {18{v[64]}})
			return v[47:0];
		return v[64] ? 48'h8000_0000_0000 : 48'h7fff_ffff_ffff;
	endfunction

	function automatic logic [47:0] mag48(input logic signed [47:0] v);
		return v[47] ? 48'(-v) : 48'(v);
	endfunction

endpackage
`default_nettype wire

// ===== sv/kpt_if.sv =====
// ---------------------------------------------------------------------------
// kpt_if
// Valid/ready channels of the point tracker: measurement, result, config.
// ---------------------------------------------------------------------------
`default_nettype none
interface kpt_meas_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] meas_x;
	logic signed [31:0] meas_y;
	modport source (output valid, meas_x, meas_y, input ready);
	modport sink   (input valid, meas_x, meas_y, output ready);
endinterface

interface kpt_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] est_x;
	logic signed [31:0] est_y;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic [3:0]         heading;
	logic [31:0]        track_age;
	logic               seeded;
	modport source (output valid, est_x, est_y, vel_x, vel_y, heading, track_age, seeded,
		input ready);
	modport sink   (input valid, est_x, est_y, vel_x, vel_y, heading, track_age, seeded,
		output ready);
endinterface

interface kpt_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/kalman_point_tracker_core.sv =====
// ---------------------------------------------------------------------------
// kalman_point_tracker_core
// Constant-velocity 2-D point tracker with heading from a position ring.
// ---------------------------------------------------------------------------
// One measurement in, one result out. The first measurement after reset seeds
// the track; every later one, when the innovation variance is positive, runs
// the bit-per-cycle divider for five product-quotients per axis, each after
// a four-pass 24x24 multiplier. The result sits in an output register; the
// next measurement is taken once the sequencer is back at idle, even while
// that result is still waiting. A register write to index 0, 1 or 2 resets
// the error covariance to the CFG_INIT_COV value on the diagonal.
`default_nettype none
`include "kalman_point_tracker_core_defines.svh"
module kalman_point_tracker_core #(
	parameter int HISTORY_DEPTH = kpt_pkg::KPT_HISTORY_DEPTH
) (
	input wire logic  clk,
	input wire logic  arst_n,
	kpt_meas_if.sink  meas,
	kpt_res_if.source res,
	kpt_cfg_if.sink   cfg
);
	import kpt_pkg::*;

	kpt_cmd_t  cmd;
	kpt_stat_t stat;

	assign cfg.ready = 1'b1;

	kpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (meas.valid),
		.in_ready  (meas.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	kpt_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.meas_x    (meas.meas_x),
		.meas_y    (meas.meas_y),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.est_x     (res.est_x),
		.est_y     (res.est_y),
		.vel_x     (res.vel_x),
		.vel_y     (res.vel_y),
		.heading   (res.heading),
		.track_age (res.track_age),
		.seeded    (res.seeded)
	);

	// checks
	`KPT_ASSERT_NXT(a_busy_after_take, meas.valid && meas.ready, !meas.ready, "took a second transaction while busy")
	`KPT_ASSERT_NOW(a_heading_range, res.valid, res.heading <= KPT_HEAD_MAX, "heading code out of range")
	`KPT_ASSERT_NOW(a_seed_still, res.valid && res.seeded, res.heading == 4'(HD_STILL) && res.track_age == '0, "seeding result carries motion")

endmodule
`default_nettype wire

// ===== sv/kpt_ctrl.sv =====
// ---------------------------------------------------------------------------
// kpt_ctrl
// Sequencer: steps the datapath through seed or predict/correct, ring push
// and heading classification, then hands the result to the output register.
// ---------------------------------------------------------------------------
`default_nettype none
module kpt_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire kpt_pkg::kpt_stat_t stat,
	output kpt_pkg::kpt_cmd_t   cmd
);
	import kpt_pkg::*;

	typedef enum logic [16:0] {
		S_IDLE  = 17'h00001, S_SEED  = 17'h00002, S_PRED  = 17'h00004,
		S_PRED2 = 17'h00008, S_MDLD  = 17'h00010, S_MUL   = 17'h00020,
		S_DINIT = 17'h00040, S_DIV   = 17'h00080, S_MDST  = 17'h00100,
		S_UPD   = 17'h00200, S_PUSH  = 17'h00400, S_RD    = 17'h00800,
		S_RDW   = 17'h01000, S_HMLD  = 17'h02000, S_HMUL  = 17'h04000,
		S_HMST  = 17'h08000, S_CLS   = 17'h10000
	} kpt_state_t;

	kpt_state_t state_q, state_d;
	logic       ax_q, ax_d;
	logic [2:0] k_q, k_d;
	logic [5:0] cnt_q, cnt_d;
	logic       ov_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ov_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		ax_d    = ax_q;
		k_d     = k_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.ax  = ax_q;
		cmd.k   = k_q;
		cmd.mul_j = cnt_q[1:0];
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					ax_d     = 1'b0;
					state_d  = stat.started ? S_PRED : S_SEED;
				end
			end
			S_SEED: begin
				cmd.seed = 1'b1;
				state_d  = S_PUSH;
			end
			S_PRED: begin
				cmd.pred = 1'b1;
				state_d  = S_PRED2;
			end
			S_PRED2: begin
				cmd.pred2 = 1'b1;
				state_d   = S_MDLD;
				k_d       = '0;
			end
			S_MDLD: begin
				// a non-positive innovation variance skips the correction
				if (!stat.pos) begin
					state_d = S_UPD;
				end else begin
					cmd.md_ld = 1'b1;
					cnt_d     = '0;
					state_d   = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_step = (cnt_q < 6'(KPT_MUL_STEPS));
				cnt_d        = cnt_q + 6'd1;
				if (cnt_q == 6'(KPT_MUL_STEPS))
					state_d = S_DINIT;
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				cnt_d        = '0;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 6'd1;
				if (cnt_q == 6'(KPT_DIV_STEPS - 1))
					state_d = S_MDST;
			end
			S_MDST: begin
				cmd.md_st = 1'b1;
				k_d       = k_q + 3'd1;
				state_d   = (k_q == 3'd4) ? S_UPD : S_MDLD;
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				if (ax_q) begin
					state_d = S_PUSH;
				end else begin
					ax_d    = 1'b1;
					state_d = S_PRED;
				end
			end
			S_PUSH: begin
				cmd.push = 1'b1;
				state_d  = S_RD;
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_RDW;
			end
			S_RDW: begin
				cmd.hcalc = 1'b1;
				k_d       = '0;
				state_d   = S_HMLD;
			end
			S_HMLD: begin
				cmd.hm_ld = 1'b1;
				cnt_d     = '0;
				state_d   = S_HMUL;
			end
			S_HMUL: begin
				cmd.mul_step = (cnt_q < 6'(KPT_MUL_STEPS));
				cnt_d        = cnt_q + 6'd1;
				if (cnt_q == 6'(KPT_MUL_STEPS))
					state_d = S_HMST;
			end
			S_HMST: begin
				cmd.hm_st = 1'b1;
				k_d       = k_q + 3'd1;
				state_d   = (k_q == 3'd2) ? S_CLS : S_HMLD;
			end
			S_CLS: begin
				// wait for the output register to free up
				if (!ov_q || out_ready) begin
					cmd.ld_out = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ax_q    <= 1'b0;
			k_q     <= '0;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			ax_q    <= ax_d;
			k_q     <= k_d;
			cnt_q   <= cnt_d;
			if (cmd.ld_out)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ===== sv/kpt_dp.sv =====
// ---------------------------------------------------------------------------
// kpt_dp
// Filter datapath: state and covariance registers, 24x24 partial-product
// multiplier, bit-per-cycle divider, position ring and heading compare.
// ---------------------------------------------------------------------------
`default_nettype none
module kpt_dp #(
	parameter int HISTORY_DEPTH = kpt_pkg::KPT_HISTORY_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire kpt_pkg::kpt_cmd_t  cmd,
	output kpt_pkg::kpt_stat_t      stat,
	input  wire logic signed [31:0] meas_x,
	input  wire logic signed [31:0] meas_y,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	output logic signed [31:0]      est_x,
	output logic signed [31:0]      est_y,
	output logic signed [31:0]      vel_x,
	output logic signed [31:0]      vel_y,
	output logic [3:0]              heading,
	output logic [31:0]             track_age,
	output logic                    seeded
);
	import kpt_pkg::*;

	localparam int IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int FW = $clog2(HISTORY_DEPTH + 1);
	localparam int OW = FW + 1;

	// configuration
	logic [31:0] q_q, r_q, p_q;
	// filter state, per axis
	logic signed [31:0] x_q [2];
	logic signed [31:0] v_q [2];
	logic signed [47:0] a_q [2];
	logic signed [47:0] b_q [2];
	logic signed [47:0] c_q [2];
	logic signed [31:0] mz_q [2];
	logic               started_q, seeded_q;
	logic [31:0]        age_q;
	// predict
	logic signed [31:0] xp_q;
	logic signed [47:0] ap_q, bp_q, cp_q;
	logic signed [49:0] s_q;
	logic signed [32:0] e_q;
	logic               pos_q;
	// multiplier
	logic [47:0] ma_q, mb_q, pp_q;
	logic        neg_q, ppv_q;
	logic [1:0]  pj_q;
	logic [95:0] acc_q;
	// divider
	logic [48:0] rem_q;
	logic [62:0] lo_q, quo_q;
	logic        cap_q;
	logic signed [63:0] t_q [5];
	// ring and heading
	logic [63:0]   ring_q [HISTORY_DEPTH];
	logic [63:0]   rdata_q;
	logic [IW-1:0] head_q;
	logic [FW-1:0] fill_q;
	logic [32:0]   ux_q, uy_q;
	logic          dxpos_q, dypos_q, still_q;
	logic [69:0]   sq_q, x2_q, y2_q;

	// combinational helpers
	logic               ax;
	logic signed [31:0] xs, vs;
	logic signed [47:0] as_, bs, cs;
	logic signed [47:0] op_n, op_m, e48;
	logic [23:0]        ca, cb;
	logic [95:0]        pp_sh;
	logic [48:0]        dvs;
	logic [49:0]        trial;
	logic [62:0]        qcap;
	logic signed [63:0] qres;
	logic [OW-1:0]      osum;
	logic [IW-1:0]      oidx;
	logic signed [32:0] dx, dy;
	logic [33:0]        usum;
	logic [3:0]         hd;
	logic [31:0]        p_new;

	assign ax  = cmd.ax;
	assign xs  = x_q[ax];
	assign vs  = v_q[ax];
	assign as_ = a_q[ax];
	assign bs  = b_q[ax];
	assign cs  = c_q[ax];
	assign e48 = 48'(e_q);
	assign stat.pos     = pos_q;
	assign stat.started = started_q;

	// product-quotient operands
	always_comb begin
		case (cmd.k)
			3'd0:    begin op_n = ap_q; op_m = e48;  end
			3'd1:    begin op_n = bp_q; op_m = e48;  end
			3'd2:    begin op_n = ap_q; op_m = ap_q; end
			3'd3:    begin op_n = ap_q; op_m = bp_q; end
			default: begin op_n = bp_q; op_m = bp_q; end
		endcase
	end

	// partial product chunks and alignment
	always_comb begin
		ca = cmd.mul_j[1] ? ma_q[47:24] : ma_q[23:0];
		cb = cmd.mul_j[0] ? mb_q[47:24] : mb_q[23:0];
		case (pj_q)
			2'd0:    pp_sh = 96'(pp_q);
			2'd3:    pp_sh = 96'(pp_q) << 48;
			default: pp_sh = 96'(pp_q) << 24;
		endcase
	end

	// divider step and quotient finish
	assign dvs   = s_q[48:0];
	assign trial = {rem_q, lo_q[62]};
	assign qcap  = (cap_q || quo_q > KPT_QUOT_CAP) ? KPT_QUOT_CAP : quo_q;
	assign qres  = neg_q ? -64'(qcap) : 64'(qcap);

	// oldest ring entry after the push
	assign osum = OW'(head_q) + OW'(HISTORY_DEPTH) - OW'(fill_q);
	assign oidx = (osum >= OW'(HISTORY_DEPTH)) ? IW'(osum - OW'(HISTORY_DEPTH)) : IW'(osum);

	assign dx   = 33'(x_q[0]) - 33'($signed(rdata_q[63:32]));
	assign dy   = 33'(x_q[1]) - 33'($signed(rdata_q[31:0]));
	assign usum = 34'(ux_q) + 34'(uy_q);
	assign p_new = (cfg_index == CFG_INIT_COV) ? cfg_data : p_q;

	// sector from exact squared compares against tan 22.5 deg
	always_comb begin
		if (still_q)
			hd = HD_STILL;
		else if (sq_q < {x2_q[68:0], 1'b0})
			hd = dxpos_q ? HD_R : HD_L;
		else if (sq_q < {y2_q[68:0], 1'b0})
			hd = dypos_q ? HD_D : HD_U;
		else if (dxpos_q)
			hd = dypos_q ? HD_DR : HD_UR;
		else
			hd = dypos_q ? HD_DL : HD_UL;
	end

	// control-side state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q       <= KPT_Q_RST;
			r_q       <= KPT_R_RST;
			p_q       <= KPT_P_RST;
			started_q <= 1'b0;
			age_q     <= '0;
			head_q    <= '0;
			fill_q    <= '0;
			ppv_q     <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				x_q[i] <= '0;
				v_q[i] <= '0;
				a_q[i] <= 48'(KPT_P_RST);
				b_q[i] <= '0;
				c_q[i] <= 48'(KPT_P_RST);
			end
		end else begin
			ppv_q <= cmd.mul_step;
			// register write resets the covariance
			if (cfg_we && (cfg_index == CFG_PROCESS_NOISE || cfg_index == CFG_MEAS_NOISE ||
					cfg_index == CFG_INIT_COV)) begin
				case (cfg_index)
					CFG_PROCESS_NOISE: q_q <= cfg_data;
					CFG_MEAS_NOISE:    r_q <= cfg_data;
					default:           p_q <= cfg_data;
				endcase
				for (int i = 0; i < 2; i++) begin
					a_q[i] <= 48'(p_new);
					b_q[i] <= '0;
					c_q[i] <= 48'(p_new);
				end
			end
			if (cmd.seed) begin
				x_q[0]    <= mz_q[0];
				x_q[1]    <= mz_q[1];
				v_q[0]    <= '0;
				v_q[1]    <= '0;
				started_q <= 1'b1;
			end
			// correction, or prediction alone when the innovation variance is not positive
			if (cmd.upd) begin
				if (pos_q) begin
					x_q[ax] <= sat32(65'(xp_q) + 65'(t_q[0]));
					v_q[ax] <= sat32(65'(vs) + 65'(t_q[1]));
					a_q[ax] <= sat48(65'(ap_q) - 65'(t_q[2]));
					b_q[ax] <= sat48(65'(bp_q) - 65'(t_q[3]));
					c_q[ax] <= sat48(65'(cp_q) - 65'(t_q[4]));
				end else begin
					x_q[ax] <= xp_q;
					a_q[ax] <= ap_q;
					b_q[ax] <= bp_q;
					c_q[ax] <= cp_q;
				end
			end
			if (cmd.push) begin
				head_q <= (head_q == IW'(HISTORY_DEPTH - 1)) ? '0 : head_q + IW'(1);
				if (fill_q < FW'(HISTORY_DEPTH))
					fill_q <= fill_q + FW'(1);
				if (!seeded_q && age_q != '1)
					age_q <= age_q + 32'd1;
			end
		end
	end

	// arithmetic payload
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mz_q[0]  <= meas_x;
			mz_q[1]  <= meas_y;
			seeded_q <= !started_q;
		end
		// predict
		if (cmd.pred) begin
			xp_q <= sat32(65'(xs) + 65'(vs));
			ap_q <= sat48(65'(as_) + 65'(bs) + 65'(bs) + 65'(cs) + 65'(q_q));
			bp_q <= sat48(65'(bs) + 65'(cs));
			cp_q <= sat48(65'(cs) + 65'(q_q));
		end
		if (cmd.pred2) begin
			s_q   <= 50'(ap_q) + 50'(r_q);
			pos_q <= $signed(50'(ap_q) + 50'(r_q)) > 50'sd0;
			e_q   <= 33'(mz_q[ax]) - 33'(xp_q);
		end
		// multiplier
		if (cmd.md_ld) begin
			ma_q  <= mag48(op_n);
			mb_q  <= mag48(op_m);
			neg_q <= op_n[47] ^ op_m[47];
			acc_q <= '0;
		end
		if (cmd.hm_ld) begin
			case (cmd.k)
				3'd0:    begin ma_q <= 48'(usum); mb_q <= 48'(usum); end
				3'd1:    begin ma_q <= 48'(ux_q); mb_q <= 48'(ux_q); end
				default: begin ma_q <= 48'(uy_q); mb_q <= 48'(uy_q); end
			endcase
			acc_q <= '0;
		end
		if (cmd.mul_step) begin
			pp_q <= ca * cb;
			pj_q <= cmd.mul_j;
		end
		if (ppv_q)
			acc_q <= acc_q + pp_sh;
		// divider
		if (cmd.div_init) begin
			cap_q <= 49'(acc_q[95:63]) >= dvs;
			rem_q <= 49'(acc_q[95:63]);
			lo_q  <= acc_q[62:0];
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			if (trial >= 50'(dvs)) begin
				rem_q <= 49'(trial - 50'(dvs));
				quo_q <= {quo_q[61:0], 1'b1};
			end else begin
				rem_q <= trial[48:0];
				quo_q <= {quo_q[61:0], 1'b0};
			end
			lo_q <= {lo_q[61:0], 1'b0};
		end
		if (cmd.md_st)
			t_q[cmd.k] <= qres;
		// heading
		if (cmd.push)
			ring_q[head_q] <= {x_q[0], x_q[1]};
		if (cmd.rd)
			rdata_q <= ring_q[oidx];
		if (cmd.hcalc) begin
			ux_q    <= dx[32] ? 33'(-dx) : 33'(dx);
			uy_q    <= dy[32] ? 33'(-dy) : 33'(dy);
			dxpos_q <= !dx[32] && dx != '0;
			dypos_q <= !dy[32] && dy != '0;
			still_q <= (fill_q < FW'(2)) || (dx == '0 && dy == '0);
		end
		if (cmd.hm_st) begin
			case (cmd.k)
				3'd0:    sq_q <= acc_q[69:0];
				3'd1:    x2_q <= acc_q[69:0];
				default: y2_q <= acc_q[69:0];
			endcase
		end
		// output register
		if (cmd.ld_out) begin
			est_x     <= x_q[0];
			est_y     <= x_q[1];
			vel_x     <= v_q[0];
			vel_y     <= v_q[1];
			heading   <= hd;
			track_age <= age_q;
			seeded    <= seeded_q;
		end
	end

endmodule
`default_nettype wire

// ===== tb/kalman_point_tracker_core_test.sv =====
// ---------------------------------------------------------------------------
// kalman_point_tracker_core_test
// Self-checking bench for the 2-D constant-velocity point tracker.
// Measurements go in over a valid/ready channel, and the noise registers are
// changed between phases. A behavioral copy of the filter predicts each
// result. Results are checked field by field, in order, under random stalls.
// ---------------------------------------------------------------------------
`default_nettype none
module kalman_point_tracker_core_test;
	import kpt_pkg::*;

	localparam logic [1:0] CFG_BAD_INDEX = 2'd3;
	localparam int HD = KPT_HISTORY_DEPTH;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
	} point_t;

	typedef struct {
		logic signed [31:0] est_x, est_y, vel_x, vel_y;
		logic [3:0]         heading;
		logic [31:0]        track_age;
		logic               seeded;
	} track_out_t;

	typedef struct {
		logic [1:0]  index;
		logic [31:0] data;
	} reg_write_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	kpt_meas_if meas ();
	kpt_res_if  res ();
	kpt_cfg_if  cfg ();

	kalman_point_tracker_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.meas   (meas.sink),
		.res    (res.source),
		.cfg    (cfg.sink)
	);

	always #2 clk = ~clk;

	// pending stimulus and expected results
	point_t     meas_q[$];
	reg_write_t wr_q[$];
	track_out_t track_q[$];
	int         errors = 0;
	bit         no_gaps = 0;

	// tracker model state
	bit          started;
	longint      pos[2], vel[2], cov_a[2], cov_b[2], cov_c[2];
	logic [31:0] q_noise, r_noise, p_init;
	point_t      ring[HD];
	int          fill, head;
	logic [31:0] age;

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint clamp48(longint v);
		longint top = (64'sd1 <<< 47) - 1;
		if (v > top) return top;
		if (v < -top - 1) return -top - 1;
		return v;
	endfunction

	function automatic logic [63:0] abs64(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	// n*m/d toward zero, magnitude capped at 2^62
	function automatic longint scaled_quot(longint n, longint m, longint d);
		logic [127:0] prod, quot;
		prod = abs64(n) * abs64(m);
		quot = prod / 128'(d);
		if (quot > (128'd1 << 62)) quot = 128'd1 << 62;
		return ((n < 0) != (m < 0)) ? -longint'(quot) : longint'(quot);
	endfunction

	function automatic void reset_cov();
		for (int i = 0; i < 2; i++) begin
			cov_a[i] = p_init;
			cov_b[i] = 0;
			cov_c[i] = p_init;
		end
	endfunction

	// predict and correct one axis
	function automatic void correct_axis(int ax, longint z);
		longint xp, ap, bp, cp, s, e;
		xp = clamp32(pos[ax] + vel[ax]);
		ap = clamp48(cov_a[ax] + 2 * cov_b[ax] + cov_c[ax] + q_noise);
		bp = clamp48(cov_b[ax] + cov_c[ax]);
		cp = clamp48(cov_c[ax] + q_noise);
		s = ap + r_noise;
		if (s > 0) begin
			e = z - xp;
			pos[ax] = clamp32(xp + scaled_quot(ap, e, s));
			vel[ax] = clamp32(vel[ax] + scaled_quot(bp, e, s));
			cov_a[ax] = clamp48(ap - scaled_quot(ap, ap, s));
			cov_b[ax] = clamp48(bp - scaled_quot(ap, bp, s));
			cov_c[ax] = clamp48(cp - scaled_quot(bp, bp, s));
		end else begin
			pos[ax] = xp;
			cov_a[ax] = ap;
			cov_b[ax] = bp;
			cov_c[ax] = cp;
		end
	endfunction

	// 8-sector direction of newest minus oldest ring entry
	function automatic logic [3:0] ring_heading();
		int          nw, od;
		longint      dx, dy;
		logic [63:0] ux, uy;
		logic [127:0] ss, xx, yy;
		if (fill < 2) return HD_STILL;
		nw = (head + HD - 1) % HD;
		od = (head + HD - fill) % HD;
		dx = longint'(ring[nw].x) - longint'(ring[od].x);
		dy = longint'(ring[nw].y) - longint'(ring[od].y);
		if (dx == 0 && dy == 0) return HD_STILL;
		ux = abs64(dx);
		uy = abs64(dy);
		ss = 128'(ux + uy) * 128'(ux + uy);
		xx = (128'(ux) * 128'(ux)) << 1;
		yy = (128'(uy) * 128'(uy)) << 1;
		if (ss < xx) return dx > 0 ? HD_R : HD_L;
		if (ss < yy) return dy > 0 ? HD_D : HD_U;
		if (dx > 0) return dy > 0 ? HD_DR : HD_UR;
		return dy > 0 ? HD_DL : HD_UL;
	endfunction

	function automatic track_out_t track_step(point_t m);
		track_out_t o;
		if (!started) begin
			pos[0] = m.x;
			pos[1] = m.y;
			vel[0] = 0;
			vel[1] = 0;
			started = 1;
			o.seeded = 1'b1;
		end else begin
			correct_axis(0, m.x);
			correct_axis(1, m.y);
			if (age != 32'hffff_ffff) age++;
			o.seeded = 1'b0;
		end
		ring[head].x = pos[0][31:0];
		ring[head].y = pos[1][31:0];
		head = (head + 1) % HD;
		if (fill < HD) fill++;
		o.est_x = pos[0][31:0];
		o.est_y = pos[1][31:0];
		o.vel_x = vel[0][31:0];
		o.vel_y = vel[1][31:0];
		o.heading = ring_heading();
		o.track_age = age;
		return o;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		errors++;
	endtask

	function automatic int pick_gap();
		int r;
		if (no_gaps) return 0;
		r = $urandom_range(0, 19);
		if (r < 12) return 0;
		if (r < 18) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// input side: model updates on each accepted transaction
	bit meas_taken, wr_taken;
	always @(posedge clk) begin
		if (arst_n && meas.valid && meas.ready) begin
			track_q.insert(track_q.size(), track_step('{meas.meas_x, meas.meas_y}));
			meas_q.delete(0);
			meas_taken <= 1'b1;
		end
		if (arst_n && cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_PROCESS_NOISE: q_noise = cfg.data;
				CFG_MEAS_NOISE:    r_noise = cfg.data;
				CFG_INIT_COV:      p_init = cfg.data;
				default:           ;
			endcase
			if (cfg.index != CFG_BAD_INDEX) reset_cov();
			wr_q.delete(0);
			wr_taken <= 1'b1;
		end
	end

	// measurement driver
	int meas_gap = 0;
	always @(negedge clk) begin
		if (!meas.valid || meas_taken) begin
			meas_taken <= 1'b0;
			if (meas_gap > 0 || meas_q.size() == 0) begin
				meas.valid <= 1'b0;
				if (meas_gap > 0) meas_gap--;
			end else begin
				meas.valid <= 1'b1;
				meas.meas_x <= meas_q[0].x;
				meas.meas_y <= meas_q[0].y;
				meas_gap = pick_gap();
			end
		end
	end

	// register write driver
	always @(negedge clk) begin
		if (!cfg.valid || wr_taken) begin
			wr_taken <= 1'b0;
			if (wr_q.size() == 0) begin
				cfg.valid <= 1'b0;
			end else begin
				cfg.valid <= 1'b1;
				cfg.index <= wr_q[0].index;
				cfg.data <= wr_q[0].data;
			end
		end
	end

	// result monitor with random backpressure
	int res_gap = 0;
	always @(negedge clk) begin
		if (res_gap > 0) begin
			res.ready <= 1'b0;
			res_gap--;
		end else begin
			res.ready <= 1'b1;
			res_gap = pick_gap();
		end
	end

	always @(posedge clk) begin
		track_out_t w;
		if (arst_n && res.valid && res.ready) begin
			if (track_q.size() == 0) begin
				report_mismatch("unexpected result", 0, 0);
			end else begin
				w = track_q[0];
				track_q.delete(0);
				if (res.est_x !== w.est_x) report_mismatch("est_x", res.est_x, w.est_x);
				if (res.est_y !== w.est_y) report_mismatch("est_y", res.est_y, w.est_y);
				if (res.vel_x !== w.vel_x) report_mismatch("vel_x", res.vel_x, w.vel_x);
				if (res.vel_y !== w.vel_y) report_mismatch("vel_y", res.vel_y, w.vel_y);
				if (res.heading !== w.heading)
					report_mismatch("heading", res.heading, w.heading);
				if (res.track_age !== w.track_age)
					report_mismatch("track_age", res.track_age, w.track_age);
				if (res.seeded !== w.seeded) report_mismatch("seeded", res.seeded, w.seeded);
			end
		end
	end

	function automatic logic [31:0] noise_value();
		case ($urandom_range(0, 5))
			0: return 32'd1;
			1: return 32'hffff_ffff;
			2: return $urandom_range(1, 65535);
			3: return $urandom_range(1, 32'h0010_0000);
			default: return $urandom() | 32'd1;
		endcase
	endfunction

	task automatic wait_idle();
		while (meas_q.size() != 0 || wr_q.size() != 0 || track_q.size() != 0
			|| meas.valid || cfg.valid)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic add_point(longint x, longint y);
		point_t p;
		p.x = 32'(clamp32(x));
		p.y = 32'(clamp32(y));
		meas_q.insert(meas_q.size(), p);
	endtask

	task automatic add_write(logic [1:0] index, logic [31:0] data);
		reg_write_t w;
		w.index = index;
		w.data = data;
		wr_q.insert(wr_q.size(), w);
	endtask

	// random sequence: mostly moving targets, some jumps and raw noise
	task automatic random_phase(int n);
		longint x, y, vx, vy;
		x = $signed($urandom_range(0, 32'h0400_0000)) - 64'sh0200_0000;
		y = $signed($urandom_range(0, 32'h0400_0000)) - 64'sh0200_0000;
		vx = $signed($urandom_range(0, 32'h0008_0000)) - 64'sh0004_0000;
		vy = $signed($urandom_range(0, 32'h0008_0000)) - 64'sh0004_0000;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 19))
				0, 1: add_point($signed($urandom()), $signed($urandom()));
				2: begin
					vx = $signed($urandom()) >>> $urandom_range(4, 16);
					vy = $signed($urandom()) >>> $urandom_range(4, 16);
				end
				3: add_point(x, y);
				default: begin
					x = clamp32(x + vx);
					y = clamp32(y + vy);
					add_point(x + $signed($urandom_range(0, 8192)) - 4096,
						y + $signed($urandom_range(0, 8192)) - 4096);
				end
			endcase
		end
	endtask

	initial begin
		meas.valid = 1'b0;
		meas.meas_x = '0;
		meas.meas_y = '0;
		cfg.valid = 1'b0;
		cfg.index = CFG_PROCESS_NOISE;
		cfg.data = '0;
		res.ready = 1'b0;
		started = 0;
		fill = 0;
		head = 0;
		age = 0;
		q_noise = KPT_Q_RST;
		r_noise = KPT_R_RST;
		p_init = KPT_P_RST;
		for (int i = 0; i < 2; i++) begin
			pos[i] = 0;
			vel[i] = 0;
		end
		reset_cov();
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: seeding, standing still, every direction, field extremes
		add_point(64'sh0064_0000, 64'sh0064_0000);
		add_point(64'sh0064_0000, 64'sh0064_0000);
		add_point(64'sh0064_0000, 64'sh0064_0000);
		add_point(64'sh0264_0000, 64'sh0064_0000);
		add_point(64'sh0264_0000, 64'sh0264_0000);
		add_point(64'sh0064_0000, 64'sh0464_0000);
		add_point(-64'sh0400_0000, 64'sh0464_0000);
		add_point(-64'sh0800_0000, -64'sh0400_0000);
		add_point(-64'sh0800_0000, -64'sh0c00_0000);
		add_point(64'sh0400_0000, -64'sh1000_0000);
		add_point(64'sh7fff_ffff, 64'sh7fff_ffff);
		add_point(-64'sh8000_0000, -64'sh8000_0000);
		add_point(64'sh7fff_ffff, -64'sh8000_0000);
		add_point(-64'sh8000_0000, 64'sh7fff_ffff);
		add_point(0, 0);
		add_point(-1, 1);
		wait_idle();

		// register extremes, including an ignored index
		add_write(CFG_PROCESS_NOISE, 32'hffff_ffff);
		add_write(CFG_MEAS_NOISE, 32'd1);
		add_write(CFG_INIT_COV, 32'hffff_ffff);
		add_write(CFG_BAD_INDEX, 32'h1234_5678);
		wait_idle();
		add_point(64'sh7fff_ffff, -64'sh8000_0000);
		add_point(-64'sh8000_0000, 64'sh7fff_ffff);
		add_point(64'sh0001_0000, 64'sh0001_0000);
		wait_idle();

		// random phases, most with fresh register settings
		for (int ph = 0; ph < 60; ph++) begin
			no_gaps = ($urandom_range(0, 4) == 0);
			if (ph % 3 == 0) begin
				add_write(CFG_PROCESS_NOISE, noise_value());
				add_write(CFG_MEAS_NOISE, noise_value());
				add_write(CFG_INIT_COV, noise_value());
			end else if (ph % 3 == 1) begin
				add_write(kpt_cfg_idx_t'($urandom_range(0, 2)), noise_value());
			end
			if (ph == 30) begin
				add_write(CFG_PROCESS_NOISE, KPT_Q_RST);
				add_write(CFG_MEAS_NOISE, KPT_R_RST);
				add_write(CFG_INIT_COV, KPT_P_RST);
			end
			wait_idle();
			random_phase(32);
			wait_idle();
		end

		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("** kalman_point_tracker_core: PASSED **");
		end else begin
			$display("** kalman_point_tracker_core: FAILED **");
		end
		$finish;
	end

	// watchdog
	initial begin
		#40000000;
		$display("** kalman_point_tracker_core: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire

// ===== kalman_point_tracker_core.f =====
+incdir+sv
sv/kpt_pkg.sv
sv/kpt_if.sv
sv/kpt_ctrl.sv
sv/kpt_dp.sv
sv/kalman_point_tracker_core.sv
tb/kalman_point_tracker_core_test.sv
